// ===== rtl/cgntt_pkg.sv =====
// cgntt_pkg: shared constants, types and arithmetic helpers for the
// constant-geometry ntt core; no dependencies
package cgntt_pkg;

    localparam int POINTS      = 256;
    localparam int HALF_POINTS = POINTS / 2;
    localparam int AW          = $clog2(POINTS);
    localparam int TW_AW       = $clog2(HALF_POINTS);
    localparam int STAGES      = AW;

    localparam logic [31:0] MOD_Q     = 32'd8380417;
    localparam logic [31:0] MONT_QINV = 32'd58728449;
    localparam logic [31:0] INV_SCALE = 32'd16382;

    localparam logic [2:0] OP_LOAD_COEF = 3'd0;
    localparam logic [2:0] OP_LOAD_FWD  = 3'd1;
    localparam logic [2:0] OP_LOAD_INV  = 3'd2;
    localparam logic [2:0] OP_RUN       = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] REG_INVERSE_MODE = 2'd0;

    // controller -> datapath commands
    typedef struct packed {
        logic            rd_en;      // issue a coefficient read
        logic [AW-1:0]   rd_addr;
        logic            tw_en;      // issue a twiddle read
        logic [TW_AW-1:0] tw_addr;
        logic            tw_inv;
        logic            ld_x;       // capture first operand of a pair
        logic            ld_y;       // capture second operand, start butterfly
        logic            first;      // stage 0: no multiply
        logic            scale;      // final scaling pass
        logic [TW_AW-1:0] j;         // pair index of the butterfly being started
    } t_dp_cmd;

    function automatic logic [7:0] bitrev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) r[k] = v[7-k];
        return r;
    endfunction

endpackage

// ===== rtl/cgntt_ram.sv =====
// cgntt_ram: generic single-port-write, single-read ram with registered read
// no dependencies
module cgntt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cgntt_datapath.sv =====
// cgntt_datapath: coefficient ping-pong rams, twiddle rams, pipelined
// montgomery butterfly; depends on cgntt_pkg and cgntt_ram
module cgntt_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cgntt_pkg::t_dp_cmd        i_cmd,
    input  logic                      i_bank,      // bank holding current data
    input  logic                      i_ext_we,    // external coefficient load
    input  logic                      i_tw_we_fwd,
    input  logic                      i_tw_we_inv,
    input  logic [cgntt_pkg::AW-1:0]  i_ext_addr,
    input  logic [31:0]               i_ext_data,
    output logic [31:0]               o_rd_data,   // read data of current bank
    output logic                      o_wb_busy    // results still in flight
);
    import cgntt_pkg::*;

    logic [31:0] w_rd0, w_rd1, w_twf, w_twi;
    logic        w_we0, w_we1;
    logic [AW-1:0] w_wa0, w_wa1;
    logic [31:0] w_wd0, w_wd1;

    // butterfly pipeline registers
    logic [31:0] r_x, r_y_d, r_tw_d;
    logic        r_tw_inv_d;
    logic [31:0] r_x1, r_x2, r_x3;
    logic [63:0] r_prod;
    logic [31:0] r_t;
    logic [63:0] r_prod2, r_prod3, r_tq;
    logic [31:0] r_even_f;
    logic [3:0]  r_v;           // valid per stage
    logic [2:0]  r_first, r_scale;
    logic [TW_AW-1:0] r_j [3];
    logic        r_wb_pend;     // second half of butterfly write
    logic [31:0] r_hi_val;
    logic [TW_AW-1:0] r_hi_j;
    logic        r_ld_y_d;
    logic        r_first_d, r_scale_d;
    logic [TW_AW-1:0] r_j_d;

    assign o_rd_data = i_bank ? w_rd1 : w_rd0;

    // operand capture: read data appears in the cycle after the command
    logic r_ld_x_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_x_d <= 1'b0;
            r_ld_y_d <= 1'b0;
        end else begin
            r_ld_x_d <= i_cmd.ld_x;
            r_ld_y_d <= i_cmd.ld_y;
        end
        r_first_d  <= i_cmd.first;
        r_scale_d  <= i_cmd.scale;
        r_j_d      <= i_cmd.j;
        r_tw_inv_d <= i_cmd.tw_inv;
        if (r_ld_x_d) r_x <= o_rd_data;
    end

    logic [31:0] w_y_in, w_tw_in;
    assign w_y_in  = o_rd_data;
    assign w_tw_in = r_scale_d ? INV_SCALE : (r_tw_inv_d ? w_twi : w_twf);

    // stage 1: signed multiply; stage 2: t = lo*qinv; stage 3: t*q;
    // stage 4: subtract and form sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], r_ld_y_d};
        end
        r_prod <= $signed(w_y_in) * $signed(w_tw_in);
        r_y_d  <= w_y_in;
        r_x1   <= r_x;
        r_first[0] <= r_first_d;
        r_scale[0] <= r_scale_d;
        r_j[0]     <= r_j_d;

        r_t     <= r_prod[31:0] * MONT_QINV;
        r_prod2 <= r_prod;
        r_x2    <= r_first[0] ? r_y_d : r_x1;
        r_tw_d  <= r_x1;
        r_first[1] <= r_first[0];
        r_scale[1] <= r_scale[0];
        r_j[1]     <= r_j[0];

        r_tq <= $signed(r_t) * $signed({1'b0, MOD_Q});
        r_prod3 <= r_prod2;
        r_x3 <= r_x2;
        r_even_f <= r_tw_d;
        r_first[2] <= r_first[1];
        r_scale[2] <= r_scale[1];
        r_j[2]     <= r_j[1];
    end

    // for stage 0 the "odd" operand is y itself (no multiply)
    logic [63:0] w_diff;
    logic [31:0] w_odd, w_even;
    assign w_diff = r_prod3 - r_tq;
    assign w_odd  = r_first[2] ? r_x3 : w_diff[63:32];
    assign w_even = r_even_f;

    // butterfly write-back: lower half this cycle, upper half next
    logic [31:0] w_lo, w_hi;
    assign w_lo = w_even + w_odd;
    assign w_hi = w_even - w_odd + MOD_Q;

    logic        w_bf_we;
    logic [AW-1:0] w_bf_addr;
    logic [31:0] w_bf_data;
    always_comb begin
        w_bf_we   = 1'b0;
        w_bf_addr = '0;
        w_bf_data = w_lo;
        if (r_v[2]) begin
            w_bf_we = 1'b1;
            if (r_scale[2]) begin
                w_bf_addr = {r_j[2], 1'b0} ^ {{(AW-1){1'b0}}, 1'b0};
                w_bf_data = w_diff[63:32];
            end else begin
                w_bf_addr = {1'b0, r_j[2]};
            end
        end else if (r_wb_pend) begin
            w_bf_we   = 1'b1;
            w_bf_addr = {1'b1, r_hi_j};
            w_bf_data = r_hi_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
        end else begin
            r_wb_pend <= r_v[2] && !r_scale[2];
        end
        r_hi_val <= w_hi;
        r_hi_j   <= r_j[2];
    end

    // scale pass rebuilds the full coefficient index from j and the first bit: see controller
    logic [AW-1:0] w_scale_addr;
    assign w_scale_addr = {r_j[2], r_first[2]};

    // butterflies write into the other bank; scaling writes back in place
    // into the other bank as well (controller flips the bank afterwards)
    logic [AW-1:0] w_wb_addr;
    assign w_wb_addr = (r_v[2] && r_scale[2]) ? w_scale_addr : w_bf_addr;

    assign w_we0 = i_bank ? w_bf_we : i_ext_we;
    assign w_we1 = i_bank ? i_ext_we : w_bf_we;
    assign w_wa0 = i_bank ? w_wb_addr : i_ext_addr;
    assign w_wa1 = i_bank ? i_ext_addr : w_wb_addr;
    assign w_wd0 = i_bank ? w_bf_data : i_ext_data;
    assign w_wd1 = i_bank ? i_ext_data : w_bf_data;

    assign o_wb_busy = r_ld_x_d | r_ld_y_d | (|r_v) | r_wb_pend;

    cgntt_ram #(.WIDTH(32), .DEPTH(POINTS)) u_bank0 (
        .i_clk, .i_we(w_we0), .i_waddr(w_wa0), .i_wdata(w_wd0),
        .i_raddr(i_cmd.rd_addr), .o_rdata(w_rd0)
    );
    cgntt_ram #(.WIDTH(32), .DEPTH(POINTS)) u_bank1 (
        .i_clk, .i_we(w_we1), .i_waddr(w_wa1), .i_wdata(w_wd1),
        .i_raddr(i_cmd.rd_addr), .o_rdata(w_rd1)
    );
    cgntt_ram #(.WIDTH(32), .DEPTH(HALF_POINTS)) u_twf (
        .i_clk, .i_we(i_tw_we_fwd), .i_waddr(i_ext_addr[TW_AW-1:0]),
        .i_wdata(i_ext_data), .i_raddr(i_cmd.tw_addr), .o_rdata(w_twf)
    );
    cgntt_ram #(.WIDTH(32), .DEPTH(HALF_POINTS)) u_twi (
        .i_clk, .i_we(i_tw_we_inv), .i_waddr(i_ext_addr[TW_AW-1:0]),
        .i_wdata(i_ext_data), .i_raddr(i_cmd.tw_addr), .o_rdata(w_twi)
    );

`ifndef SYNTHESIS
    // butterfly write-back never collides with an external load
    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bf_we |-> !i_ext_we) else $error("write clash");
    // upper-half write always follows a lower-half write
    a_hi_after_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> $past(r_v[2])) else $error("orphan upper write");
    // pipeline valid moves one stage a cycle
    a_pipe_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> $past(r_v[0])) else $error("pipeline valid broken");
`endif
endmodule

// ===== rtl/cgntt_ctrl.sv =====
// cgntt_ctrl: sequencer for load, read and the eight-stage transform
// depends on cgntt_pkg
module cgntt_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2:0]               i_op,
    input  logic [cgntt_pkg::AW-1:0] i_index,
    input  logic                     i_inverse,
    input  logic                     i_wb_busy,
    output cgntt_pkg::t_dp_cmd       o_cmd,
    output logic                     o_bank,
    output logic                     o_ext_we,
    output logic                     o_tw_we_fwd,
    output logic                     o_tw_we_inv,
    output logic                     o_busy,
    output logic                     o_rd_strobe,  // read data valid next cycle
    output logic                     o_done
);
    import cgntt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0] r_state, n_state;
    logic [3:0] r_stage, n_stage;       // 0..7 butterflies, 8 scaling
    logic [AW:0] r_cnt, n_cnt;          // issue slot counter
    logic       r_bank, n_bank;
    logic       r_inv, n_inv;
    logic       w_acc;

    assign w_acc = i_start && (r_state == S_IDLE);

    always_comb begin
        logic [TW_AW-1:0] j;
        logic [2:0] s;
        n_state = r_state;
        n_stage = r_stage;
        n_cnt   = r_cnt;
        n_bank  = r_bank;
        n_inv   = r_inv;
        o_cmd   = '0;
        o_ext_we    = w_acc && (i_op == OP_LOAD_COEF);
        o_tw_we_fwd = w_acc && (i_op == OP_LOAD_FWD) && !i_index[AW-1];
        o_tw_we_inv = w_acc && (i_op == OP_LOAD_INV) && !i_index[AW-1];
        o_rd_strobe = w_acc && (i_op == OP_READ);
        o_done = 1'b0;
        j = r_cnt[AW-1:1];
        s = 3'd7 - r_stage[2:0];
        if (o_rd_strobe) begin
            o_cmd.rd_en   = 1'b1;
            o_cmd.rd_addr = i_index;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_op == OP_RUN) begin
                    n_state = S_ISSUE;
                    n_stage = '0;
                    n_cnt   = '0;
                    n_inv   = i_inverse;
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.tw_inv = r_inv;
                if (r_stage[3]) begin
                    // scaling: one coefficient per slot through the multiplier
                    o_cmd.rd_addr = r_cnt[AW-1:0];
                    o_cmd.ld_y    = 1'b1;
                    o_cmd.scale   = 1'b1;
                    o_cmd.j       = r_cnt[AW-1:1];
                    o_cmd.first   = r_cnt[0];
                end else begin
                    o_cmd.j     = j;
                    o_cmd.first = (r_stage == 4'd0);
                    if (r_stage == 4'd0)
                        o_cmd.rd_addr = bitrev8({j, r_cnt[0]});
                    else
                        o_cmd.rd_addr = {j, r_cnt[0]};
                    o_cmd.ld_x = !r_cnt[0];
                    o_cmd.ld_y = r_cnt[0];
                    o_cmd.tw_en   = r_cnt[0];
                    o_cmd.tw_addr = (j >> s) << s;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(POINTS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_wb_busy) begin
                    n_bank = !r_bank;
                    n_cnt  = '0;
                    if (r_stage == 4'(STAGES - 1) && !r_inv) begin
                        n_state = S_DONE;
                    end else if (r_stage[3]) begin
                        n_state = S_DONE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
            r_cnt   <= '0;
            r_bank  <= 1'b0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_cnt   <= n_cnt;
            r_bank  <= n_bank;
            r_inv   <= n_inv;
        end
    end

    assign o_bank = r_bank;
    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_done_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DRAIN)) else $error("done out of order");
    a_idle_no_bf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.ld_y) else $error("butterfly while idle");
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bank != $past(r_bank)) |-> $past(r_state == S_DRAIN))
        else $error("bank flipped outside drain");
`endif
endmodule

// ===== rtl/constant_geometry_ntt_256_core.sv =====
// constant_geometry_ntt_256_core: 256-point ntt mod 8380417, top level
// uses command channel with start/busy, strobed results, apb register port
// operations: load coefficient, load forward or inverse twiddle, run, read.
// an item is taken when i_start is high and o_busy is low.
// loads are written in the cycle they are taken and give no result. a read
// returns its coefficient on o_kind/o_coef_index/o_coef_value with o_valid
// high in the cycle after it is taken. a run holds o_busy for the
// transform: 8 stages, each issuing one ram read per slot for its 256
// coefficients and then draining the pipeline, plus a scaling pass for
// inverse, then one done cycle; the bank's single read port sets the pace.
// o_valid with kind 1, in the last busy cycle, marks the end of a run.
// results stand for exactly one cycle; the receiver cannot stall them.
// reset clears the controller and inverse_mode; coefficient and twiddle
// rams keep no reset value and must be loaded before use. inverse_mode
// is at apb address 0; the user must write it only while idle, unenforced.
module constant_geometry_ntt_256_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_index,
    input  logic signed [31:0] i_value,
    output logic        o_valid,
    output logic        o_kind,
    output logic [7:0]  o_coef_index,
    output logic signed [31:0] o_coef_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cgntt_pkg::*;

    t_dp_cmd     w_cmd;
    logic        w_bank, w_ext_we, w_twf_we, w_twi_we, w_wb_busy;
    logic        w_rd_strobe, w_done;
    logic [31:0] w_rd_data;
    logic        r_inverse;
    logic        r_rd_pend;
    logic [7:0]  r_rd_idx;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_INVERSE_MODE) ? {31'd0, r_inverse} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == REG_INVERSE_MODE)
                r_inverse <= pwdata[0];
            r_rd_pend <= w_rd_strobe;
        end
        if (w_rd_strobe) r_rd_idx <= i_index;
    end

    assign o_valid      = r_rd_pend | w_done;
    assign o_kind       = w_done ? KIND_DONE : KIND_READ;
    assign o_coef_index = r_rd_pend ? r_rd_idx : 8'd0;
    assign o_coef_value = r_rd_pend ? w_rd_data : 32'd0;

    cgntt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start, .i_op, .i_index,
        .i_inverse(r_inverse), .i_wb_busy(w_wb_busy),
        .o_cmd(w_cmd), .o_bank(w_bank), .o_ext_we(w_ext_we),
        .o_tw_we_fwd(w_twf_we), .o_tw_we_inv(w_twi_we),
        .o_busy, .o_rd_strobe(w_rd_strobe), .o_done(w_done)
    );

    cgntt_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_bank(w_bank),
        .i_ext_we(w_ext_we), .i_tw_we_fwd(w_twf_we), .i_tw_we_inv(w_twi_we),
        .i_ext_addr(i_index), .i_ext_data(i_value),
        .o_rd_data(w_rd_data), .o_wb_busy(w_wb_busy)
    );
endmodule
